### hdl/sd_command_completion_tracker_core_assert.svh
// Assertion macros for the SD command completion tracker.
// Used by the checker; needs nothing else.
`ifndef SD_COMMAND_COMPLETION_TRACKER_CORE_ASSERT_SVH
`define SD_COMMAND_COMPLETION_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SDCCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdcct: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SDCCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdcct: assertion failed");

`endif

### hdl/sdcct_pkg.sv
// Types and constants of the SD command completion tracker.
// Stand-alone; used by the interfaces, the core and its checker.
`default_nettype none

package sdcct_pkg;

  // Opcodes of an event word
  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STATUS = 3'd1;
  localparam logic [2:0] OP_DMA    = 3'd2;
  localparam logic [2:0] OP_DATA0  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // Command and transfer status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_HOST    = 3'd2;
  localparam logic [2:0] ST_INTEG   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // Response kinds
  localparam logic [1:0] RESP_NONE = 2'd0;
  localparam logic [1:0] RESP_BAD  = 2'd3;

  // Latched command flag positions
  localparam int unsigned LF_DATA  = 0;
  localparam int unsigned LF_WRITE = 1;
  localparam int unsigned LF_CRC   = 2;

  // Controller status flag groups
  localparam logic [8:0] SF_HOST    = 9'h003;
  localparam logic [8:0] SF_INTEG   = 9'h00C;
  localparam logic [8:0] SF_TIMEOUT = 9'h030;
  localparam logic [8:0] SF_CCRC    = 9'h040;
  localparam logic [8:0] SF_DATAEND = 9'h080;

  // Interrupt enable bits
  localparam logic [9:0] M_TXUNDER  = 10'h001;
  localparam logic [9:0] M_RXOVER   = 10'h002;
  localparam logic [9:0] M_DCRC     = 10'h004;
  localparam logic [9:0] M_STBIT    = 10'h008;
  localparam logic [9:0] M_CTIMEOUT = 10'h010;
  localparam logic [9:0] M_DTIMEOUT = 10'h020;
  localparam logic [9:0] M_CCRC     = 10'h040;
  localparam logic [9:0] M_DATAEND  = 10'h080;
  localparam logic [9:0] M_RESPEND  = 10'h100;
  localparam logic [9:0] M_CMDSENT  = 10'h200;

  typedef struct packed {
    logic [2:0] opcode;
    logic       data_mode;
    logic       write_mode;
    logic       check_crc;
    logic [1:0] response_kind;
    logic [8:0] status_flags;
    logic [2:0] dma_result;
    logic       dma_start_ok;
    logic       data0_level;
  } evt_t;

  typedef struct packed {
    logic [2:0] cmd_status;
    logic       done_res;
    logic [9:0] irq_mask;
    logic [1:0] wait_response;
    logic       data_phase_start;
    logic       data_read_dir;
    logic       dma_start;
    logic       busy_wait;
  } res_t;

endpackage

`default_nettype wire

### hdl/sdcct_if.sv
// Valid/ready channels of the SD command completion tracker.
// Depends on sdcct_pkg for the word types.
`default_nettype none

interface sdcct_evt_if;
  logic               valid;
  logic               ready;
  sdcct_pkg::evt_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdcct_res_if;
  logic               valid;
  logic               ready;
  sdcct_pkg::res_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdcct_cfg_if;
  logic               valid;
  logic               ready;
  logic [31:0]        data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/sd_command_completion_tracker_core.sv
// SD host command completion tracker, top level.
// Depends on sdcct_pkg and the channel interfaces in sdcct_if.sv.
//
// Takes one event word per clock cycle unless the result side stalls, and returns
// exactly one result word per event, registered, in the cycle after the event is
// accepted. The state update and result are worked out in one pass of shallow priority
// logic; the deepest path is the 32-bit busy-release tick counter and its compare
// against busy_timeout_ticks. A result register with valid decouples the sides: a new
// event is taken whenever the result register is empty or its word is taken in the same
// cycle. The configuration channel is always ready and writes busy_timeout_ticks.
`default_nettype none

module sd_command_completion_tracker_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdcct_evt_if.sink  evt_i,
  sdcct_cfg_if.sink  cfg_i,
  sdcct_res_if.source res_o
);
  import sdcct_pkg::*;

  logic [31:0] tmo_q;
  logic [2:0]  cmd_q, cmd_d;
  logic [2:0]  xfer_q, xfer_d;
  logic [9:0]  ie_q, ie_d;
  logic [2:0]  lf_q, lf_d;
  logic        wait_q, wait_d;
  logic [31:0] cnt_q, cnt_d;
  logic        res_valid_q, res_valid_d;
  res_t        res_q, res_d;

  logic        accept;
  logic        complete;
  logic        done;
  logic        dstart;
  logic        rdir;
  logic [1:0]  wresp;
  logic [1:0]  resp;
  logic [2:0]  dres;
  logic [9:0]  mask;
  logic [31:0] cnt_inc;

  assign evt_i.ready = !res_valid_q || res_o.ready;
  assign accept      = evt_i.valid && evt_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cmd_d    = cmd_q;
    xfer_d   = xfer_q;
    ie_d     = ie_q;
    lf_d     = lf_q;
    wait_d   = wait_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    dstart   = 1'b0;
    rdir     = 1'b0;
    wresp    = RESP_NONE;
    complete = 1'b0;
    mask     = '0;
    resp     = (evt_i.data.response_kind == RESP_BAD) ? RESP_NONE
                                                       : evt_i.data.response_kind;
    dres     = (evt_i.data.dma_result > ST_TIMEOUT) ? ST_HOST : evt_i.data.dma_result;
    cnt_inc  = (cnt_q < tmo_q) ? cnt_q + 32'd1 : cnt_q;

    unique case (evt_i.data.opcode)
      OP_START: begin
        if (evt_i.data.data_mode) begin
          mask = mask | M_DTIMEOUT | M_DATAEND;
          if (evt_i.data.check_crc) mask = mask | M_DCRC;
          if (evt_i.data.write_mode) mask = mask | M_TXUNDER;
          else mask = mask | M_RXOVER | M_STBIT;
        end
        if (resp == RESP_NONE) mask = mask | M_CMDSENT;
        else mask = mask | M_CCRC | M_CTIMEOUT | M_RESPEND;
        if (evt_i.data.check_crc) mask = mask | M_CCRC;
        ie_d           = mask;
        lf_d[LF_DATA]  = evt_i.data.data_mode;
        lf_d[LF_WRITE] = evt_i.data.write_mode;
        lf_d[LF_CRC]   = evt_i.data.check_crc;
        cmd_d          = ST_BUSY;
        xfer_d         = ST_OK;
        wait_d         = 1'b0;
        cnt_d          = '0;
        wresp          = resp;
      end
      OP_STATUS: begin
        wait_d = 1'b0;
        cnt_d  = '0;
        priority if ((evt_i.data.status_flags & SF_HOST) != '0) begin
          cmd_d = ST_HOST;
        end else if ((evt_i.data.status_flags & SF_INTEG) != '0) begin
          cmd_d = ST_INTEG;
        end else if ((evt_i.data.status_flags & SF_TIMEOUT) != '0) begin
          cmd_d = ST_TIMEOUT;
        end else if ((evt_i.data.status_flags & SF_CCRC) != '0) begin
          cmd_d = lf_q[LF_CRC] ? ST_INTEG : ST_OK;
        end else if ((evt_i.data.status_flags & SF_DATAEND) != '0) begin
          if (xfer_q != ST_BUSY) complete = 1'b1;
          else ie_d = '0;
        end else if (lf_q[LF_DATA]) begin
          dstart = 1'b1;
          rdir   = !lf_q[LF_WRITE];
          xfer_d = ST_BUSY;
          if (!evt_i.data.dma_start_ok) begin
            xfer_d   = ST_HOST;
            complete = 1'b1;
          end
        end else begin
          complete = 1'b1;
        end
      end
      OP_DMA: begin
        xfer_d = dres;
        if (lf_q[LF_WRITE]) begin
          ie_d     = '0;
          complete = 1'b1;
        end else if (ie_q == '0) begin
          complete = 1'b1;
        end
      end
      OP_DATA0: begin
        if (wait_q) begin
          wait_d = 1'b0;
          cnt_d  = '0;
          cmd_d  = xfer_q;
          done   = 1'b1;
        end
      end
      OP_TICK: begin
        if (wait_q && tmo_q != '0) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= tmo_q) begin
            wait_d = 1'b0;
            cnt_d  = '0;
            cmd_d  = ST_TIMEOUT;
            done   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (complete) begin
      if (evt_i.data.data0_level) begin
        cmd_d = xfer_d;
      end else begin
        wait_d = 1'b1;
        cnt_d  = '0;
      end
    end

    if (evt_i.data.opcode == OP_STATUS && cmd_d != ST_BUSY) begin
      ie_d = '0;
      done = 1'b1;
    end
    if (evt_i.data.opcode == OP_DMA && cmd_d != ST_BUSY) begin
      done = 1'b1;
    end

    res_d.cmd_status       = cmd_d;
    res_d.done_res         = done;
    res_d.irq_mask         = ie_d;
    res_d.wait_response    = wresp;
    res_d.data_phase_start = dstart;
    res_d.data_read_dir    = rdir;
    res_d.dma_start        = dstart;
    res_d.busy_wait        = wait_d;
  end

  assign res_valid_d = accept || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q       <= '0;
      cmd_q       <= ST_OK;
      xfer_q      <= ST_OK;
      ie_q        <= '0;
      lf_q        <= '0;
      wait_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        tmo_q <= cfg_i.data;
      end
      if (accept) begin
        cmd_q  <= cmd_d;
        xfer_q <= xfer_d;
        ie_q   <= ie_d;
        lf_q   <= lf_d;
        wait_q <= wait_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

### hdl/sdcct_checker.sv
// Port-level checker for the SD command completion tracker, bound to the top level.
// Depends on sdcct_pkg and sd_command_completion_tracker_core_assert.svh.
`default_nettype none
`include "sd_command_completion_tracker_core_assert.svh"

module sdcct_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            res_valid_i,
  input wire logic            res_ready_i,
  input wire sdcct_pkg::res_t res_data_i
);
  import sdcct_pkg::*;

  `SDCCT_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i))
  `SDCCT_ASSERT_IMP(a_dma_follows_phase, clk_i, rst_ni, res_valid_i, res_data_i.dma_start == res_data_i.data_phase_start)
  `SDCCT_ASSERT_IMP(a_dir_needs_phase, clk_i, rst_ni, res_valid_i && res_data_i.data_read_dir, res_data_i.data_phase_start)
  `SDCCT_ASSERT_IMP(a_start_is_busy, clk_i, rst_ni, res_valid_i && res_data_i.wait_response != RESP_NONE, res_data_i.cmd_status == ST_BUSY && !res_data_i.done_res && !res_data_i.busy_wait)

endmodule

bind sd_command_completion_tracker_core sdcct_checker u_sdcct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

`default_nettype wire
